// ===== sv/kmva_pkg.sv =====
// Shared types, constants and note frequency table for the key matrix voice allocator.
`default_nettype none

package kmva_pkg;

    localparam int SLOTS_DEF       = 4;
    localparam int KEYS_DEF        = 13;
    localparam int MATRIX_SIDE_DEF = 4;

    localparam int LINE_W   = 4;   // row and column line count
    localparam int KEY_W    = 4;
    localparam int FREQ_W   = 13;
    localparam int OCT_W    = 3;
    localparam int LINE_IDX_W = 3; // row/column position; values 4 and up read as no line
    localparam logic [OCT_W-1:0] OCTAVE_RST = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVAL
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic key_step;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic key_done;
        logic pend_any;
        logic out_free;
    } dp_status_t;

    // row = octave - 1, column = key
    localparam logic [FREQ_W-1:0] FREQ_ROM [0:6][0:15] = '{
        '{13'd32,   13'd34,   13'd36,   13'd38,   13'd41,   13'd43,   13'd46,   13'd48,
          13'd51,   13'd55,   13'd58,   13'd61,   13'd65,   13'd73,   13'd77,   13'd82},
        '{13'd65,   13'd69,   13'd73,   13'd77,   13'd82,   13'd87,   13'd92,   13'd97,
          13'd103,  13'd110,  13'd116,  13'd123,  13'd130,  13'd146,  13'd155,  13'd164},
        '{13'd130,  13'd138,  13'd146,  13'd155,  13'd164,  13'd174,  13'd184,  13'd195,
          13'd207,  13'd220,  13'd233,  13'd246,  13'd261,  13'd293,  13'd311,  13'd329},
        '{13'd261,  13'd277,  13'd293,  13'd311,  13'd329,  13'd349,  13'd369,  13'd391,
          13'd415,  13'd440,  13'd466,  13'd493,  13'd523,  13'd587,  13'd622,  13'd659},
        '{13'd523,  13'd554,  13'd587,  13'd622,  13'd659,  13'd698,  13'd739,  13'd783,
          13'd830,  13'd880,  13'd932,  13'd987,  13'd1046, 13'd1174, 13'd1244, 13'd1318},
        '{13'd1046, 13'd1108, 13'd1174, 13'd1244, 13'd1318, 13'd1396, 13'd1479, 13'd1567,
          13'd1661, 13'd1760, 13'd1864, 13'd1975, 13'd2093, 13'd2349, 13'd2489, 13'd2637},
        '{13'd2093, 13'd2217, 13'd2349, 13'd2489, 13'd2637, 13'd2793, 13'd2959, 13'd3135,
          13'd3322, 13'd3520, 13'd3729, 13'd3951, 13'd4186, 13'd4698, 13'd4978, 13'd5274}
    };

    // octave 0 mutes
    function automatic logic [FREQ_W-1:0] note_freq(input logic [OCT_W-1:0] oct,
                                                    input logic [KEY_W-1:0] key);
        logic [OCT_W-1:0] row;
        begin
            row = oct - 3'd1;
            if (oct == '0)
            begin
                note_freq = '0;
            end
            else
            begin
                note_freq = FREQ_ROM[row][key];
            end
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/kmva_ctrl.sv =====
// Controller state machine: scan phase, event phase, beat acceptance.
`default_nettype none

module kmva_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire kmva_pkg::dp_status_t status,
    output kmva_pkg::ctrl_cmd_t      cmd
);
    import kmva_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.key_done)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (!status.pend_any)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        cmd           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                cmd.load      = s_axis_tvalid;
            end
            ST_SCAN:
            begin
                cmd.key_step = 1'b1;
            end
            ST_EVAL:
            begin
                cmd.emit = status.pend_any && status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/kmva_dp.sv =====
// Datapath: key scan counters, slot table, event selection and output register.
`default_nettype none

module kmva_dp
#(
    parameter int SLOTS       = kmva_pkg::SLOTS_DEF,
    parameter int KEYS        = kmva_pkg::KEYS_DEF,
    parameter int MATRIX_SIDE = kmva_pkg::MATRIX_SIDE_DEF,
    parameter int OUT_W       = 24
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire kmva_pkg::ctrl_cmd_t            cmd,
    output kmva_pkg::dp_status_t                status,
    input  wire logic [2*kmva_pkg::LINE_W-1:0]  s_axis_tdata,
    input  wire logic                           cfg_we,
    input  wire logic [kmva_pkg::OCT_W-1:0]     cfg_wdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [OUT_W-1:0]                    m_axis_tdata,
    output logic                                m_axis_tlast
);
    import kmva_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int PAD_W  = OUT_W - SLOT_W - 1 - KEY_W - FREQ_W;

    logic [LINE_W-1:0]     rows_reg, rows_next;
    logic [LINE_W-1:0]     cols_reg, cols_next;
    logic [KEY_W-1:0]      key_cnt_reg, key_cnt_next;
    logic [LINE_IDX_W-1:0] row_cnt_reg, row_cnt_next;
    logic [LINE_IDX_W-1:0] col_cnt_reg, col_cnt_next;
    logic [KEY_W-1:0]      slot_key_reg [SLOTS];
    logic [KEY_W-1:0]      slot_key_next [SLOTS];
    logic [SLOTS-1:0]      held_reg, held_next;
    logic [SLOTS-1:0]      sounding_reg, sounding_next;
    logic [CNT_W-1:0]      held_count_reg, held_count_next;
    logic [OCT_W-1:0]      octave_reg, octave_next;

    logic                  out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]     out_slot_reg, out_slot_next;
    logic                  out_start_reg, out_start_next;
    logic [KEY_W-1:0]      out_key_reg, out_key_next;
    logic [FREQ_W-1:0]     out_freq_reg, out_freq_next;
    logic                  out_last_reg, out_last_next;

    logic                  pressed;
    logic                  row_bit;
    logic                  col_bit;
    logic                  hit_any;
    logic [SLOT_W-1:0]     hit_idx;
    logic                  free_any;
    logic [SLOT_W-1:0]     free_idx;
    logic [SLOTS-1:0]      pend_mask;
    logic                  pend_any;
    logic [SLOT_W-1:0]     pend_idx;
    logic [SLOTS-1:0]      pend_rest;

    assign row_bit  = !row_cnt_reg[LINE_IDX_W-1] && rows_reg[row_cnt_reg[1:0]];
    assign col_bit  = !col_cnt_reg[LINE_IDX_W-1] && cols_reg[col_cnt_reg[1:0]];
    assign pressed  = row_bit && col_bit;
    assign pend_mask = held_reg ^ sounding_reg;

    always_comb
    begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        pend_any = 1'b0;
        pend_idx = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (!hit_any && held_reg[s] && slot_key_reg[s] == key_cnt_reg)
            begin
                hit_any = 1'b1;
                hit_idx = SLOT_W'(s);
            end
            if (!free_any && !held_reg[s])
            begin
                free_any = 1'b1;
                free_idx = SLOT_W'(s);
            end
            if (!pend_any && pend_mask[s])
            begin
                pend_any = 1'b1;
                pend_idx = SLOT_W'(s);
            end
        end
    end

    always_comb
    begin
        pend_rest = pend_mask;
        pend_rest[pend_idx] = 1'b0;
    end

    always_comb
    begin
        status.key_done = (key_cnt_reg == KEY_W'(KEYS - 1));
        status.pend_any = pend_any;
        status.out_free = !out_valid_reg || m_axis_tready;
    end

    always_comb
    begin
        rows_next       = rows_reg;
        cols_next       = cols_reg;
        key_cnt_next    = key_cnt_reg;
        row_cnt_next    = row_cnt_reg;
        col_cnt_next    = col_cnt_reg;
        slot_key_next   = slot_key_reg;
        held_next       = held_reg;
        sounding_next   = sounding_reg;
        held_count_next = held_count_reg;
        octave_next     = octave_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_slot_next   = out_slot_reg;
        out_start_next  = out_start_reg;
        out_key_next    = out_key_reg;
        out_freq_next   = out_freq_reg;
        out_last_next   = out_last_reg;

        if (cfg_we)
        begin
            octave_next = cfg_wdata;
        end

        if (cmd.load)
        begin
            rows_next    = s_axis_tdata[LINE_W-1:0];
            cols_next    = s_axis_tdata[2*LINE_W-1:LINE_W];
            key_cnt_next = '0;
            row_cnt_next = '0;
            col_cnt_next = '0;
        end

        if (cmd.key_step)
        begin
            key_cnt_next = key_cnt_reg + 1'b1;
            if (row_cnt_reg == LINE_IDX_W'(MATRIX_SIDE - 1))
            begin
                row_cnt_next = '0;
                col_cnt_next = col_cnt_reg + 1'b1;
            end
            else
            begin
                row_cnt_next = row_cnt_reg + 1'b1;
            end

            if (pressed)
            begin
                if (!hit_any && free_any && held_count_reg < CNT_W'(SLOTS))
                begin
                    held_next[free_idx]     = 1'b1;
                    slot_key_next[free_idx] = key_cnt_reg;
                    held_count_next         = held_count_reg + 1'b1;
                end
            end
            else if (hit_any)
            begin
                held_next[hit_idx]     = 1'b0;
                slot_key_next[hit_idx] = '0;
                if (held_count_reg != '0)
                begin
                    held_count_next = held_count_reg - 1'b1;
                end
            end
        end

        if (cmd.emit)
        begin
            sounding_next[pend_idx] = held_reg[pend_idx];
            out_valid_next = 1'b1;
            out_slot_next  = pend_idx;
            out_start_next = held_reg[pend_idx];
            out_key_next   = held_reg[pend_idx] ? slot_key_reg[pend_idx] : '0;
            out_freq_next  = held_reg[pend_idx] ?
                             note_freq(octave_reg, slot_key_reg[pend_idx]) : '0;
            out_last_next  = (pend_rest == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_cnt_reg    <= '0;
            row_cnt_reg    <= '0;
            col_cnt_reg    <= '0;
            held_reg       <= '0;
            sounding_reg   <= '0;
            held_count_reg <= '0;
            octave_reg     <= OCTAVE_RST;
            out_valid_reg  <= 1'b0;
            for (int s = 0; s < SLOTS; s++)
            begin
                slot_key_reg[s] <= '0;
            end
        end
        else
        begin
            key_cnt_reg    <= key_cnt_next;
            row_cnt_reg    <= row_cnt_next;
            col_cnt_reg    <= col_cnt_next;
            held_reg       <= held_next;
            sounding_reg   <= sounding_next;
            held_count_reg <= held_count_next;
            octave_reg     <= octave_next;
            out_valid_reg  <= out_valid_next;
            slot_key_reg   <= slot_key_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rows_reg      <= rows_next;
        cols_reg      <= cols_next;
        out_slot_reg  <= out_slot_next;
        out_start_reg <= out_start_next;
        out_key_reg   <= out_key_next;
        out_freq_reg  <= out_freq_next;
        out_last_reg  <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_freq_reg, out_key_reg, out_start_reg,
                            out_slot_reg};

endmodule

`default_nettype wire

// ===== sv/key_matrix_voice_allocator.sv =====
// Top level of the key matrix voice allocator: controller plus datapath.
//
//  channel   dir  beat contents (lsb first)
//  s_axis    in   tdata: row_lines[3:0], col_lines[3:0]
//  m_axis    out  tdata: slot, start_res, key_index[3:0], frequency_hz[12:0], pad;
//                 tlast: last
//  cfg       in   cfg_we / cfg_wdata: octave[2:0]
//
//  One scan is accepted, then the matrix is walked (one key a cycle against the
//  slot table), then one event goes out per slot whose held and sounding bits differ.
//  Events wait in a single output register; a stalled m_axis holds the event phase.
//  The last event of a scan may sit in that register while the next scan is taken.
//  Reset: octave 4, all slots free and silent.
`default_nettype none

module key_matrix_voice_allocator
#(
    parameter int SLOTS       = kmva_pkg::SLOTS_DEF,
    parameter int KEYS        = kmva_pkg::KEYS_DEF,
    parameter int MATRIX_SIDE = kmva_pkg::MATRIX_SIDE_DEF,
    parameter int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    parameter int OUT_W       = ((SLOT_W + 1 + kmva_pkg::KEY_W + kmva_pkg::FREQ_W + 7) / 8) * 8
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [2*kmva_pkg::LINE_W-1:0]  s_axis_tdata,  // row_lines, col_lines
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [OUT_W-1:0]                    m_axis_tdata,  // slot, start_res, key_index,
                                                               // frequency_hz, zero pad
    output logic                                m_axis_tlast,
    input  wire logic                           cfg_we,
    input  wire logic [kmva_pkg::OCT_W-1:0]     cfg_wdata
);
    import kmva_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    kmva_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    kmva_dp
    #(
        .SLOTS       (SLOTS),
        .KEYS        (KEYS),
        .MATRIX_SIDE (MATRIX_SIDE),
        .OUT_W       (OUT_W)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .s_axis_tdata  (s_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire
